// File: sv/ioreq_pkg.sv
`default_nettype none
package ioreq_pkg;

  // field widths
  localparam int OFF_W     = 36;
  localparam int LCG_W     = 48;
  localparam int CNT_W     = 32;
  localparam int SIZE_W    = 13;
  localparam int THR_W     = 49;
  localparam int SEED_W    = 32;
  localparam int TGT_W     = 4;
  localparam int CFG_W     = 49;
  localparam int CFG_IDX_W = 3;

  // multiply-accumulate unit geometry
  localparam int CHUNK_W = 16;
  localparam int PROD_W  = OFF_W + CHUNK_W;
  localparam int ACC_W   = OFF_W + LCG_W;

  // drand48 constants
  localparam logic [OFF_W-1:0]   LCG_MUL = 36'h5_DEEC_E66D;
  localparam logic [3:0]         LCG_ADD = 4'hB;
  localparam logic [CHUNK_W-1:0] LCG_LOW = 16'h330E;

  // opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REQ_PAGES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RW_SEED     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 3'd6;

  localparam logic [SIZE_W-1:0] REQ_PAGES_RST = 13'd256;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_OLCG,
    ST_SCALE,
    ST_SIZE,
    ST_SEQ,
    ST_MIX,
    ST_FIN
  } seq_state_t;

  // control word for the multiply-accumulate unit
  typedef struct packed {
    logic       go;
    logic       first;
    logic       add_inc;
    logic [1:0] k;
  } mac_ctrl_t;

endpackage
`default_nettype wire

// File: sv/ioreq_in_if.sv
`default_nettype none
interface ioreq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [ioreq_pkg::TGT_W-1:0] target;
  logic [ioreq_pkg::OFF_W-1:0] target_pages;

  modport source (output valid, output op, output target, output target_pages, input ready);
  modport sink (input valid, input op, input target, input target_pages, output ready);
endinterface
`default_nettype wire

// File: sv/ioreq_out_if.sv
`default_nettype none
interface ioreq_out_if;
  logic                        valid;
  logic                        ready;
  logic [ioreq_pkg::OFF_W-1:0] req_offset;
  logic                        is_write;
  logic                        end_reached;
  logic [ioreq_pkg::CNT_W-1:0] issued_count;
  logic [ioreq_pkg::CNT_W-1:0] write_total;

  modport source (output valid, output req_offset, output is_write, output end_reached,
                  output issued_count, output write_total, input ready);
  modport sink (input valid, input req_offset, input is_write, input end_reached,
                input issued_count, input write_total, output ready);
endinterface
`default_nettype wire

// File: sv/io_request_generator.sv
// io_request_generator: storage traffic generator with a table of TARGETS targets.
// Channels: req_in takes one request item {op, target, target_pages}; req_out gives
// one result {req_offset, is_write, end_reached, issued_count, write_total} per item.
// Registers are written on cfg_we with cfg_idx / cfg_data; the user must write them
// only while the block is idle, as the block does not enforce it. Op start seeds a
// target; op next produces one request for it, or flags the end of the device.
// Throughput: one item at a time; req_in.ready is high only in the idle state.
// A start runs the 36-step divider for the random range; a random next makes four
// passes through the shared 36x16 multiply-accumulate, a sequential next one pass for
// the write/read LCG; end of device without wrap and a target beyond the table use neither.
// The result sits in an output register; the next item is taken while it waits,
// and a finished item holds in its last state until the register is free.
// Reset (rst, synchronous) restores the register defaults, clears all target
// entries to unseeded and drops req_out.valid.
`default_nettype none
module io_request_generator #(
  parameter int TARGETS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [ioreq_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [ioreq_pkg::CFG_W-1:0]           cfg_data,
  ioreq_in_if.sink                                   req_in,
  ioreq_out_if.source                                req_out
);

  localparam int IDX_W = (TARGETS > 1) ? $clog2(TARGETS) : 1;

  // configuration registers
  logic [ioreq_pkg::SIZE_W-1:0] req_pages;
  logic                         random_mode;
  logic                         wrap_mode;
  logic [ioreq_pkg::THR_W-1:0]  write_threshold;
  logic [ioreq_pkg::SEED_W-1:0] offset_seed;
  logic [ioreq_pkg::SEED_W-1:0] rw_seed;
  logic [ioreq_pkg::OFF_W-1:0]  range_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_pages       <= ioreq_pkg::REQ_PAGES_RST;
      random_mode     <= 1'b0;
      wrap_mode       <= 1'b0;
      write_threshold <= '0;
      offset_seed     <= '0;
      rw_seed         <= '0;
      range_limit     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ioreq_pkg::REG_REQ_PAGES:   req_pages       <= cfg_data[ioreq_pkg::SIZE_W-1:0];
        ioreq_pkg::REG_RANDOM_MODE: random_mode     <= cfg_data[0];
        ioreq_pkg::REG_WRAP_MODE:   wrap_mode       <= cfg_data[0];
        ioreq_pkg::REG_WRITE_THR:   write_threshold <= cfg_data[ioreq_pkg::THR_W-1:0];
        ioreq_pkg::REG_OFFSET_SEED: offset_seed     <= cfg_data[ioreq_pkg::SEED_W-1:0];
        ioreq_pkg::REG_RW_SEED:     rw_seed         <= cfg_data[ioreq_pkg::SEED_W-1:0];
        ioreq_pkg::REG_RANGE_LIMIT: range_limit     <= cfg_data[ioreq_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // request size, zero treated as one page
  logic [ioreq_pkg::SIZE_W-1:0] rs;
  assign rs = (req_pages == '0) ? ioreq_pkg::SIZE_W'(1) : req_pages;

  // per-target table
  logic [ioreq_pkg::OFF_W-1:0] next_offset   [TARGETS];
  logic [ioreq_pkg::OFF_W-1:0] capacity      [TARGETS];
  logic [ioreq_pkg::OFF_W-1:0] rand_range    [TARGETS];
  logic [ioreq_pkg::LCG_W-1:0] offset_lcg    [TARGETS];
  logic [ioreq_pkg::LCG_W-1:0] mix_lcg       [TARGETS];
  logic [ioreq_pkg::CNT_W-1:0] req_counter   [TARGETS];
  logic [ioreq_pkg::CNT_W-1:0] write_counter [TARGETS];
  logic [TARGETS-1:0]          seeded;

  // latched request
  logic                          op_r;
  logic [ioreq_pkg::TGT_W-1:0]   tgt_r;
  logic [ioreq_pkg::OFF_W-1:0]   pages_r;
  logic                          in_range_r;

  // sequencer
  ioreq_pkg::seq_state_t state, state_next;
  logic [2:0]            cnt;

  // working registers
  logic [ioreq_pkg::LCG_W-1:0] olcg_new;
  logic [ioreq_pkg::LCG_W-1:0] mix_new;
  logic [ioreq_pkg::OFF_W-1:0] scaled;
  logic [ioreq_pkg::OFF_W-1:0] off_r;
  logic [ioreq_pkg::OFF_W-1:0] next_r;
  logic                        end_r;

  // output register
  logic                        out_valid;
  logic [ioreq_pkg::OFF_W-1:0] out_offset;
  logic                        out_write;
  logic                        out_end;
  logic [ioreq_pkg::CNT_W-1:0] out_issued;
  logic [ioreq_pkg::CNT_W-1:0] out_writes;

  logic in_fire;
  logic fin_fire;
  logic in_range;

  // table index
  logic [IDX_W+ioreq_pkg::TGT_W-1:0] tgt_ext;
  logic [IDX_W-1:0]                  idx;
  assign tgt_ext = {{IDX_W{1'b0}}, tgt_r};
  assign idx     = tgt_ext[IDX_W-1:0];

  // entry reads; unseeded targets read zero offset and counters
  logic [ioreq_pkg::OFF_W-1:0] nxt_rd;
  logic [ioreq_pkg::OFF_W-1:0] cap_rd;
  logic [ioreq_pkg::OFF_W-1:0] range_rd;
  logic [ioreq_pkg::LCG_W-1:0] olcg_rd;
  logic [ioreq_pkg::LCG_W-1:0] mix_rd;
  logic [ioreq_pkg::CNT_W-1:0] rcnt_rd;
  logic [ioreq_pkg::CNT_W-1:0] wcnt_rd;

  assign nxt_rd   = seeded[idx] ? next_offset[idx] : '0;
  assign rcnt_rd  = seeded[idx] ? req_counter[idx] : '0;
  assign wcnt_rd  = seeded[idx] ? write_counter[idx] : '0;
  assign cap_rd   = capacity[idx];
  assign range_rd = rand_range[idx];
  assign olcg_rd  = offset_lcg[idx];
  assign mix_rd   = mix_lcg[idx];

  assign in_fire  = req_in.valid && req_in.ready;
  assign fin_fire = (state == ioreq_pkg::ST_FIN) && (!out_valid || req_out.ready);
  assign in_range = 32'(req_in.target) < 32'(TARGETS);

  // shared units
  ioreq_pkg::mac_ctrl_t           mac_ctrl;
  logic [ioreq_pkg::OFF_W-1:0]    mac_a;
  logic [ioreq_pkg::CHUNK_W-1:0]  mac_b;
  logic [ioreq_pkg::ACC_W-1:0]    mac_acc;
  logic [ioreq_pkg::LCG_W-1:0]    chunk_src;
  logic                           div_start;
  logic                           div_done;
  logic [ioreq_pkg::OFF_W-1:0]    div_q;

  ioreq_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (mac_acc)
  );

  ioreq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req_in.target_pages),
    .divisor  (rs),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequential-mode advance and end test
  logic [ioreq_pkg::OFF_W:0]   adv;
  logic [ioreq_pkg::OFF_W+1:0] adv2;
  logic                        end_hit;
  assign adv     = {1'b0, nxt_rd} + (ioreq_pkg::OFF_W + 1)'(rs);
  assign adv2    = {1'b0, adv} + (ioreq_pkg::OFF_W + 2)'(rs);
  assign end_hit = {2'b0, cap_rd} <= adv2;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ioreq_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!in_range) begin
            state_next = ioreq_pkg::ST_FIN;
          end else if (req_in.op == ioreq_pkg::OP_START) begin
            state_next = ioreq_pkg::ST_DIV;
          end else if (random_mode) begin
            state_next = ioreq_pkg::ST_OLCG;
          end else begin
            state_next = ioreq_pkg::ST_SEQ;
          end
        end
      end
      ioreq_pkg::ST_DIV:   if (div_done) state_next = ioreq_pkg::ST_FIN;
      ioreq_pkg::ST_OLCG:  if (cnt == 3'd4) state_next = ioreq_pkg::ST_SCALE;
      ioreq_pkg::ST_SCALE: if (cnt == 3'd4) state_next = ioreq_pkg::ST_SIZE;
      ioreq_pkg::ST_SIZE:  if (cnt == 3'd2) state_next = ioreq_pkg::ST_MIX;
      ioreq_pkg::ST_SEQ: begin
        state_next = (end_hit && !wrap_mode) ? ioreq_pkg::ST_FIN : ioreq_pkg::ST_MIX;
      end
      ioreq_pkg::ST_MIX:   if (cnt == 3'd4) state_next = ioreq_pkg::ST_FIN;
      ioreq_pkg::ST_FIN:   if (fin_fire) state_next = ioreq_pkg::ST_IDLE;
      default:             state_next = ioreq_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mac_ctrl     = '0;
    mac_a        = ioreq_pkg::LCG_MUL;
    chunk_src    = olcg_rd;
    req_in.ready = 1'b0;
    div_start    = 1'b0;
    unique case (state)
      ioreq_pkg::ST_IDLE: begin
        req_in.ready = 1'b1;
        div_start    = req_in.valid && in_range && (req_in.op == ioreq_pkg::OP_START);
      end
      ioreq_pkg::ST_OLCG, ioreq_pkg::ST_MIX: begin
        chunk_src        = (state == ioreq_pkg::ST_MIX) ? mix_rd : olcg_rd;
        mac_ctrl.go      = cnt < 3'd3;
        mac_ctrl.first   = cnt == 3'd0;
        mac_ctrl.add_inc = 1'b1;
        mac_ctrl.k       = cnt[1:0];
      end
      ioreq_pkg::ST_SCALE: begin
        mac_a          = range_rd;
        chunk_src      = olcg_new;
        mac_ctrl.go    = cnt < 3'd3;
        mac_ctrl.first = cnt == 3'd0;
        mac_ctrl.k     = cnt[1:0];
      end
      ioreq_pkg::ST_SIZE: begin
        mac_a          = scaled;
        chunk_src      = ioreq_pkg::LCG_W'(rs);
        mac_ctrl.go    = cnt == 3'd0;
        mac_ctrl.first = 1'b1;
      end
      default: ;
    endcase
  end

  // chunk select for the multiplier
  always_comb begin
    unique case (mac_ctrl.k)
      2'd1:    mac_b = chunk_src[2*ioreq_pkg::CHUNK_W-1:ioreq_pkg::CHUNK_W];
      2'd2:    mac_b = chunk_src[3*ioreq_pkg::CHUNK_W-1:2*ioreq_pkg::CHUNK_W];
      default: mac_b = chunk_src[ioreq_pkg::CHUNK_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ioreq_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 3'd0 : cnt + 3'd1;
    end
  end

  // request capture and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= req_in.op;
      tgt_r      <= req_in.target;
      pages_r    <= req_in.target_pages;
      in_range_r <= in_range;
      end_r      <= 1'b0;
    end
    if (state == ioreq_pkg::ST_OLCG && cnt == 3'd4) begin
      olcg_new <= mac_acc[ioreq_pkg::LCG_W-1:0];
    end
    if (state == ioreq_pkg::ST_SCALE && cnt == 3'd4) begin
      scaled <= mac_acc[ioreq_pkg::ACC_W-1:ioreq_pkg::LCG_W];
    end
    if (state == ioreq_pkg::ST_SIZE && cnt == 3'd2) begin
      off_r  <= mac_acc[ioreq_pkg::OFF_W-1:0];
      next_r <= mac_acc[ioreq_pkg::OFF_W-1:0];
    end
    if (state == ioreq_pkg::ST_MIX && cnt == 3'd4) begin
      mix_new <= mac_acc[ioreq_pkg::LCG_W-1:0];
    end
    if (state == ioreq_pkg::ST_SEQ) begin
      // end of device without wrap: no request, offset stays advanced
      if (end_hit && !wrap_mode) begin
        end_r <= 1'b1;
        off_r <= '0;
      end else begin
        off_r <= nxt_rd;
      end
      next_r <= (end_hit && wrap_mode) ? '0 : adv[ioreq_pkg::OFF_W-1:0];
    end
  end

  // result values
  logic                        wr_c;
  logic [ioreq_pkg::CNT_W-1:0] rcnt_new;
  logic [ioreq_pkg::CNT_W-1:0] wcnt_new;
  logic [ioreq_pkg::OFF_W-1:0] range_c;

  assign wr_c     = !end_r && ({1'b0, mix_new} < write_threshold);
  assign rcnt_new = end_r ? rcnt_rd : rcnt_rd + ioreq_pkg::CNT_W'(1);
  assign wcnt_new = wr_c ? wcnt_rd + ioreq_pkg::CNT_W'(1) : wcnt_rd;
  assign range_c  = ((range_limit != '0) && (div_q > range_limit)) ? range_limit : div_q;

  // seeded flags
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= '0;
    end else if (fin_fire && in_range_r && op_r == ioreq_pkg::OP_START) begin
      seeded[idx] <= 1'b1;
    end
  end

  // table write-back
  always_ff @(posedge clk) begin
    if (fin_fire && in_range_r) begin
      if (op_r == ioreq_pkg::OP_START) begin
        next_offset[idx]   <= '0;
        req_counter[idx]   <= '0;
        write_counter[idx] <= '0;
        capacity[idx]      <= pages_r;
        rand_range[idx]    <= range_c;
        offset_lcg[idx]    <= {offset_seed + ioreq_pkg::SEED_W'(tgt_r), ioreq_pkg::LCG_LOW};
        mix_lcg[idx]       <= {rw_seed + ioreq_pkg::SEED_W'(tgt_r), ioreq_pkg::LCG_LOW};
      end else begin
        next_offset[idx] <= next_r;
        if (random_mode) begin
          offset_lcg[idx] <= olcg_new;
        end
        if (!end_r) begin
          mix_lcg[idx]       <= mix_new;
          req_counter[idx]   <= rcnt_new;
          write_counter[idx] <= wcnt_new;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (req_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      if (in_range_r && op_r == ioreq_pkg::OP_NEXT) begin
        out_offset <= off_r;
        out_write  <= wr_c;
        out_end    <= end_r;
        out_issued <= rcnt_new;
        out_writes <= wcnt_new;
      end else begin
        out_offset <= '0;
        out_write  <= 1'b0;
        out_end    <= 1'b0;
        out_issued <= '0;
        out_writes <= '0;
      end
    end
  end

  assign req_out.valid        = out_valid;
  assign req_out.req_offset   = out_offset;
  assign req_out.is_write     = out_write;
  assign req_out.end_reached  = out_end;
  assign req_out.issued_count = out_issued;
  assign req_out.write_total  = out_writes;

endmodule
`default_nettype wire

// File: sv/ioreq_mac.sv
`default_nettype none
// Shared MAC, product registered first: acc = (first ? 0/inc : acc) + (a*b << 16*k).
module ioreq_mac (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ioreq_pkg::mac_ctrl_t            ctrl,
  input  wire logic [ioreq_pkg::OFF_W-1:0]     a,
  input  wire logic [ioreq_pkg::CHUNK_W-1:0]   b,
  output logic      [ioreq_pkg::ACC_W-1:0]     acc
);

  logic [ioreq_pkg::PROD_W-1:0] prod;
  ioreq_pkg::mac_ctrl_t         ctrl_q;
  logic [ioreq_pkg::ACC_W-1:0]  prod_sh;
  logic [ioreq_pkg::ACC_W-1:0]  base;

  // product stage
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl;
    end
  end

  // align product to its chunk
  always_comb begin
    unique case (ctrl_q.k)
      2'd0:    prod_sh = ioreq_pkg::ACC_W'(prod);
      2'd1:    prod_sh = ioreq_pkg::ACC_W'(prod) << ioreq_pkg::CHUNK_W;
      2'd2:    prod_sh = ioreq_pkg::ACC_W'(prod) << (2 * ioreq_pkg::CHUNK_W);
      default: prod_sh = ioreq_pkg::ACC_W'(prod) << (3 * ioreq_pkg::CHUNK_W);
    endcase
  end

  always_comb begin
    if (ctrl_q.first) begin
      base = ctrl_q.add_inc ? ioreq_pkg::ACC_W'(ioreq_pkg::LCG_ADD) : '0;
    end else begin
      base = acc;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl_q.go) begin
      acc <= base + prod_sh;
    end
  end

endmodule
`default_nettype wire

// File: sv/ioreq_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ioreq_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [ioreq_pkg::OFF_W-1:0]    dividend,
  input  wire logic [ioreq_pkg::SIZE_W-1:0]   divisor,
  output logic                                done,
  output logic      [ioreq_pkg::OFF_W-1:0]    quotient
);

  localparam int STEP_W = $clog2(ioreq_pkg::OFF_W + 1);

  logic [STEP_W-1:0]             steps;
  logic [ioreq_pkg::SIZE_W:0]    rem;
  logic [ioreq_pkg::SIZE_W-1:0]  dsr;
  logic [ioreq_pkg::SIZE_W:0]    rem_sh;
  logic                          fits;

  // trial subtract
  assign rem_sh = {rem[ioreq_pkg::SIZE_W-1:0], quotient[ioreq_pkg::OFF_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= STEP_W'(ioreq_pkg::OFF_W);
      done  <= 1'b0;
    end else begin
      done <= (steps == STEP_W'(1));
      if (steps != '0) begin
        steps <= steps - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (steps != '0) begin
      quotient <= {quotient[ioreq_pkg::OFF_W-2:0], fits};
      rem      <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
    end
  end

endmodule
`default_nettype wire

// File: sv/ioreq_chk.sv
`default_nettype none
module ioreq_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ioreq_pkg::OFF_W-1:0] req_offset,
  input wire logic                        is_write,
  input wire logic                        end_reached
);

  // reset drops the result
  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one request in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  // end of device carries no request
  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_reached) |-> (!is_write && req_offset == '0))
    else $error("end of device with a request");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(req_offset) && $stable(is_write)))
    else $error("stalled result changed");

endmodule

bind io_request_generator ioreq_chk u_ioreq_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req_in.valid),
  .in_ready    (req_in.ready),
  .out_valid   (req_out.valid),
  .out_ready   (req_out.ready),
  .req_offset  (req_out.req_offset),
  .is_write    (req_out.is_write),
  .end_reached (req_out.end_reached)
);
`default_nettype wire

// File: tb/io_request_generator_tb.sv
`timescale 1ns / 1ps
module io_request_generator_tb;

  localparam int NTGT      = 16;
  localparam int PHASES    = 8;
  localparam int PER_PHASE = 236;
  localparam int SETTLE    = 50;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic [ioreq_pkg::OFF_W-1:0] offset;
    logic                        wr;
    logic                        done;
    logic [ioreq_pkg::CNT_W-1:0] issued;
    logic [ioreq_pkg::CNT_W-1:0] writes;
  } req_res_t;

  typedef struct {
    logic                        op;
    logic [ioreq_pkg::TGT_W-1:0] tgt;
    logic [ioreq_pkg::OFF_W-1:0] pages;
    logic                        typed;
    req_res_t                    res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ioreq_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ioreq_pkg::CFG_W-1:0] cfg_data = '0;

  ioreq_in_if  req_in();
  ioreq_out_if req_out();

  io_request_generator #(.TARGETS(NTGT)) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .req_in(req_in), .req_out(req_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of registers and target table
  logic [ioreq_pkg::SIZE_W-1:0] m_pages;
  logic                         m_random, m_loop;
  logic [ioreq_pkg::THR_W-1:0]  m_thr;
  logic [ioreq_pkg::SEED_W-1:0] m_oseed, m_mseed;
  logic [ioreq_pkg::OFF_W-1:0]  m_limit;
  logic [ioreq_pkg::OFF_W-1:0]  t_next [NTGT];
  logic [ioreq_pkg::OFF_W-1:0]  t_cap [NTGT];
  logic [ioreq_pkg::OFF_W-1:0]  t_range [NTGT];
  logic [ioreq_pkg::LCG_W-1:0]  t_olcg [NTGT];
  logic [ioreq_pkg::LCG_W-1:0]  t_mlcg [NTGT];
  logic [ioreq_pkg::CNT_W-1:0]  t_reqs [NTGT];
  logic [ioreq_pkg::CNT_W-1:0]  t_wrs [NTGT];
  bit                           seeded [NTGT];

  req_res_t expected_reqs[$];
  int errors = 0;
  int n_results = 0, n_ends = 0, n_writes = 0;
  longint cycles = 0;

  function automatic logic [ioreq_pkg::LCG_W-1:0] drand_step(logic [ioreq_pkg::LCG_W-1:0] x);
    logic [95:0] p;
    p = 96'(x) * 96'(ioreq_pkg::LCG_MUL) + 96'(ioreq_pkg::LCG_ADD);
    return p[ioreq_pkg::LCG_W-1:0];
  endfunction

  function automatic logic [ioreq_pkg::LCG_W-1:0] drand_seed(
      logic [ioreq_pkg::SEED_W-1:0] base, int t);
    logic [ioreq_pkg::SEED_W-1:0] s;
    s = base + ioreq_pkg::SEED_W'(t);
    return {s, ioreq_pkg::LCG_LOW};
  endfunction

  // advance the shadow table by one request and return its result
  function automatic req_res_t predict_request(logic op, logic [ioreq_pkg::TGT_W-1:0] t,
                                               logic [ioreq_pkg::OFF_W-1:0] pages);
    req_res_t r;
    logic [ioreq_pkg::OFF_W-1:0] rs, rng, off;
    logic [39:0] adv;
    logic [83:0] prod;
    logic done;
    r = '0;
    done = 1'b0;
    rs = (m_pages == 0) ? ioreq_pkg::OFF_W'(1) : ioreq_pkg::OFF_W'(m_pages);
    if (op == ioreq_pkg::OP_START) begin
      t_next[t] = '0;
      t_reqs[t] = '0;
      t_wrs[t] = '0;
      t_cap[t] = pages;
      rng = pages / rs;
      if (m_limit != 0 && rng > m_limit) rng = m_limit;
      t_range[t] = rng;
      t_olcg[t] = drand_seed(m_oseed, t);
      t_mlcg[t] = drand_seed(m_mseed, t);
      seeded[t] = 1'b1;
      return r;
    end
    if (m_random) begin
      t_olcg[t] = drand_step(t_olcg[t]);
      prod = 84'(t_range[t]) * 84'(t_olcg[t]);
      prod = 84'(prod[83:48]) * 84'(rs);
      off = prod[ioreq_pkg::OFF_W-1:0];
      t_next[t] = off;
    end else begin
      off = t_next[t];
      adv = 40'(off) + 40'(rs);
      t_next[t] = adv[ioreq_pkg::OFF_W-1:0];
      if (40'(t_cap[t]) <= adv + 40'(rs)) begin
        if (m_loop) t_next[t] = '0;
        else begin
          done = 1'b1;
          off = '0;
        end
      end
    end
    if (!done) begin
      t_mlcg[t] = drand_step(t_mlcg[t]);
      if (49'(t_mlcg[t]) < m_thr) begin
        r.wr = 1'b1;
        t_wrs[t] = t_wrs[t] + ioreq_pkg::CNT_W'(1);
      end
      t_reqs[t] = t_reqs[t] + ioreq_pkg::CNT_W'(1);
    end
    r.offset = off;
    r.done = done;
    r.issued = t_reqs[t];
    r.writes = t_wrs[t];
    return r;
  endfunction

  // sender burst bookkeeping
  int burst_left = 0;

  task automatic send_request(logic op, logic [ioreq_pkg::TGT_W-1:0] t,
                              logic [ioreq_pkg::OFF_W-1:0] pages);
    int gap;
    req_in.valid <= 1'b1;
    req_in.op <= op;
    req_in.target <= t;
    req_in.target_pages <= pages;
    do @(negedge clk); while (!req_in.ready);
    @(posedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        req_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic issue(logic op, logic [ioreq_pkg::TGT_W-1:0] t,
                       logic [ioreq_pkg::OFF_W-1:0] pages);
    expected_reqs.push_back(predict_request(op, t, pages));
    send_request(op, t, pages);
  endtask

  task automatic drain;
    req_in.valid <= 1'b0;
    while (expected_reqs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [ioreq_pkg::CFG_IDX_W-1:0] idx,
                           logic [ioreq_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ioreq_pkg::REG_REQ_PAGES:   m_pages = val[ioreq_pkg::SIZE_W-1:0];
      ioreq_pkg::REG_RANDOM_MODE: m_random = val[0];
      ioreq_pkg::REG_WRAP_MODE:   m_loop = val[0];
      ioreq_pkg::REG_WRITE_THR:   m_thr = val[ioreq_pkg::THR_W-1:0];
      ioreq_pkg::REG_OFFSET_SEED: m_oseed = val[ioreq_pkg::SEED_W-1:0];
      ioreq_pkg::REG_RW_SEED:     m_mseed = val[ioreq_pkg::SEED_W-1:0];
      ioreq_pkg::REG_RANGE_LIMIT: m_limit = val[ioreq_pkg::OFF_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [ioreq_pkg::OFF_W-1:0] rand36;
    return {4'($urandom), 32'($urandom)};
  endfunction

  // receiver: random stalls, with long stretches of no stall
  int stall_pct = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[%0t] timeout, %0d requests still expected", $time, expected_reqs.size());
      $display("io_request_generator test failed");
      $finish;
    end
    if (cycles % 700 == 0) stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
    if (rst) req_out.ready <= 1'b0;
    else req_out.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker; handshake values are stable at the falling edge
  always @(negedge clk) begin
    req_res_t e;
    if (!rst && req_out.valid && req_out.ready) begin
      if (expected_reqs.size() == 0) begin
        $display("[%0t] result with none expected: offset %h", $time, req_out.req_offset);
        errors++;
      end else begin
        e = expected_reqs.pop_front();
        n_results++;
        if (req_out.end_reached) n_ends++;
        if (req_out.is_write) n_writes++;
        if (req_out.req_offset !== e.offset) begin
          $display("[%0t] req_offset exp %h got %h", $time, e.offset, req_out.req_offset);
          errors++;
        end
        if (req_out.is_write !== e.wr) begin
          $display("[%0t] is_write exp %b got %b", $time, e.wr, req_out.is_write);
          errors++;
        end
        if (req_out.end_reached !== e.done) begin
          $display("[%0t] end_reached exp %b got %b", $time, e.done, req_out.end_reached);
          errors++;
        end
        if (req_out.issued_count !== e.issued) begin
          $display("[%0t] issued_count exp %0d got %0d", $time, e.issued, req_out.issued_count);
          errors++;
        end
        if (req_out.write_total !== e.writes) begin
          $display("[%0t] write_total exp %0d got %0d", $time, e.writes, req_out.write_total);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    req_res_t got;
    logic [ioreq_pkg::TGT_W-1:0] t;
    logic [ioreq_pkg::OFF_W-1:0] pg, rs;
    int seq_mode;
    req_in.valid = 1'b0;
    req_in.op = ioreq_pkg::OP_START;
    req_in.target = '0;
    req_in.target_pages = '0;
    m_pages = ioreq_pkg::REQ_PAGES_RST;
    m_random = 0;
    m_loop = 0;
    m_thr = '0;
    m_oseed = '0;
    m_mseed = '0;
    m_limit = '0;
    for (int i = 0; i < NTGT; i++) begin
      t_next[i] = '0; t_cap[i] = '0; t_range[i] = '0; t_olcg[i] = '0;
      t_mlcg[i] = '0; t_reqs[i] = '0; t_wrs[i] = '0; seeded[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset settings: 256-page reads, no wrap
    rows.push_back('{ioreq_pkg::OP_START, 4'd0, 36'd1024, 1, '{0, 0, 0, 0, 0}});
    rows.push_back('{ioreq_pkg::OP_NEXT, 4'd0, 36'd0, 1, '{36'd0, 0, 0, 32'd1, 0}});
    rows.push_back('{ioreq_pkg::OP_NEXT, 4'd0, 36'd0, 1, '{36'd256, 0, 0, 32'd2, 0}});
    rows.push_back('{ioreq_pkg::OP_NEXT, 4'd0, 36'd0, 1, '{36'd0, 0, 1, 32'd2, 0}});
    rows.push_back('{ioreq_pkg::OP_NEXT, 4'd0, 36'd0, 1, '{36'd0, 0, 1, 32'd2, 0}});
    rows.push_back('{ioreq_pkg::OP_START, 4'd15, 36'hF_FFFF_FFFF, 1, '{0, 0, 0, 0, 0}});
    rows.push_back('{ioreq_pkg::OP_NEXT, 4'd15, 36'd0, 1, '{36'd0, 0, 0, 32'd1, 0}});
    rows.push_back('{ioreq_pkg::OP_NEXT, 4'd15, 36'd0, 0, '0});
    rows.push_back('{ioreq_pkg::OP_START, 4'd7, 36'd0, 1, '{0, 0, 0, 0, 0}});
    rows.push_back('{ioreq_pkg::OP_NEXT, 4'd7, 36'd0, 1, '{36'd0, 0, 1, 32'd0, 0}});
    rows.push_back('{ioreq_pkg::OP_START, 4'd0, 36'd600, 0, '0});
    rows.push_back('{ioreq_pkg::OP_NEXT, 4'd0, 36'd0, 0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      got = predict_request(row.op, row.tgt, row.pages);
      if (row.typed && got !== row.res) begin
        $display("[%0t] table row %0d: exp %h predicted %h", $time, i, row.res, got);
        errors++;
      end
      expected_reqs.push_back(row.typed ? row.res : got);
      send_request(row.op, row.tgt, row.pages);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      seq_mode = (ph % 2 == 0);
      case (ph)
        0: begin
          write_reg(ioreq_pkg::REG_REQ_PAGES, '0);
          write_reg(ioreq_pkg::REG_WRITE_THR, '0);
          write_reg(ioreq_pkg::REG_OFFSET_SEED, '0);
          write_reg(ioreq_pkg::REG_RW_SEED, '0);
          write_reg(ioreq_pkg::REG_RANGE_LIMIT, '0);
          write_reg(ioreq_pkg::REG_WRAP_MODE, '0);
        end
        1: begin
          write_reg(ioreq_pkg::REG_REQ_PAGES, ioreq_pkg::CFG_W'(4096));
          write_reg(ioreq_pkg::REG_WRITE_THR, 49'h1_0000_0000_0000);
          write_reg(ioreq_pkg::REG_OFFSET_SEED, ioreq_pkg::CFG_W'(32'hFFFF_FFFF));
          write_reg(ioreq_pkg::REG_RW_SEED, ioreq_pkg::CFG_W'(32'hFFFF_FFFF));
          write_reg(ioreq_pkg::REG_RANGE_LIMIT, ioreq_pkg::CFG_W'(36'hF_FFFF_FFFF));
          write_reg(ioreq_pkg::REG_WRAP_MODE, ioreq_pkg::CFG_W'(1));
        end
        default: begin
          write_reg(ioreq_pkg::REG_REQ_PAGES, ioreq_pkg::CFG_W'(
                    ($urandom_range(0, 4) == 0) ?
                    $urandom_range(0, 4096) : $urandom_range(1, 64)));
          write_reg(ioreq_pkg::REG_WRITE_THR, ($urandom_range(0, 3) == 0) ?
                    ioreq_pkg::CFG_W'({$urandom, $urandom}) :
                    {1'b0, 16'($urandom), 32'($urandom)});
          write_reg(ioreq_pkg::REG_OFFSET_SEED, ioreq_pkg::CFG_W'($urandom));
          write_reg(ioreq_pkg::REG_RW_SEED, ioreq_pkg::CFG_W'($urandom));
          write_reg(ioreq_pkg::REG_RANGE_LIMIT, ($urandom_range(0, 1) == 0) ?
                    ioreq_pkg::CFG_W'(rand36()) :
                    ioreq_pkg::CFG_W'($urandom_range(0, 1000)));
          write_reg(ioreq_pkg::REG_WRAP_MODE, ioreq_pkg::CFG_W'($urandom_range(0, 1)));
        end
      endcase
      write_reg(ioreq_pkg::REG_RANDOM_MODE, ioreq_pkg::CFG_W'(!seq_mode));
      rs = (m_pages == 0) ? ioreq_pkg::OFF_W'(1) : ioreq_pkg::OFF_W'(m_pages);

      for (int n = 0; n < PER_PHASE; n++) begin
        // hold off until the block has caught up
        if (ph == 3 && n == PER_PHASE / 2) begin
          req_in.valid <= 1'b0;
          do @(posedge clk); while (expected_reqs.size() != 0);
        end
        t = ioreq_pkg::TGT_W'($urandom_range(0, NTGT - 1));
        if (!seeded[t] || $urandom_range(0, 19) == 0) begin
          if (seq_mode || $urandom_range(0, 5) == 0)
            pg = rs * ioreq_pkg::OFF_W'($urandom_range(0, 40)) +
                 ioreq_pkg::OFF_W'($urandom_range(0, 32'(2 * rs)));
          else
            pg = ($urandom_range(0, 9) == 0) ? 36'hF_FFFF_FFFF : rand36();
          issue(ioreq_pkg::OP_START, t, pg);
        end else begin
          issue(ioreq_pkg::OP_NEXT, t, rand36());
        end
      end
    end

    drain();
    $display("covered %0d results (%0d end of device, %0d writes) over %0d settings",
             n_results, n_ends, n_writes, PHASES + 1);
    if (errors == 0) $display("io_request_generator test passed");
    else $display("io_request_generator test failed");
    $finish;
  end

endmodule
